// ===== rtl/riff_wav_header_parser_macros.svh =====
// Assertion helpers for the checker file of this block.
`ifndef RIFF_WAV_HEADER_PARSER_MACROS_SVH
`define RIFF_WAV_HEADER_PARSER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RWHP_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion on the block clock clk_i and reset rst_ni.
`define RWHP_ASSERT(lbl, prop, msg) \
  `RWHP_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/rwhp_pkg.sv =====
`timescale 1ns / 1ps

package rwhp_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_RIFF    = 3'd1,
    ST_NO_WAVE    = 3'd2,
    ST_FMT_SHORT  = 3'd3,
    ST_NOT_PCM    = 3'd4,
    ST_DATA_FIRST = 3'd5,
    ST_TRUNCATED  = 3'd6
  } status_e;

  // One result; the last member sits in the lowest bits.
  typedef struct packed {
    logic [31:0] body_len;
    logic [31:0] body_start;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    status_e     status;
  } result_t;

  localparam int unsigned ResultW  = $bits(result_t);
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;
  localparam int unsigned InDataW  = 8;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
  localparam logic [15:0] PCM_FORMAT    = 16'd1;
  localparam logic [31:0] RIFF_LAST_POS = 32'd3;
  localparam logic [31:0] WAVE_LAST_POS = 32'd11;

endpackage

// ===== rtl/riff_wav_header_parser.sv =====
`timescale 1ns / 1ps
// A result is registered into the result queue on the byte that decides it; older results go out first.
// Throughput: one file byte per cycle, sustained, as long as results are drained.
// The slave side stays ready while the two-entry result queue has a free slot.
// Reset (rst_ni low, asynchronous) clears the parser state and empties the result queue;
// a byte marked last also returns the parser to its reset state.
module riff_wav_header_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave side, one file byte per request.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rwhp_pkg::InDataW-1:0]       s_axis_tdata,  // [7:0] file_byte
  input  logic                               s_axis_tlast,  // is_last
  // Master side, one result per request.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] status, [18:3] channel_count, [50:19] rate_hz,
  // [66:51] sample_bits, [98:67] body_start, [130:99] body_len, rest zero
  output logic [rwhp_pkg::OutDataW-1:0]      m_axis_tdata
);

  // The parser walks the file one byte per accepted request. Every byte shifts into a
  // 64-bit window of the newest eight bytes, so tags and little-endian sizes can be read
  // straight out of the window on the byte that completes them. A result is produced on
  // the byte that decides a check, on the data chunk header, or on a marked final byte.

  logic              accept;
  logic              res_valid;
  rwhp_pkg::result_t res;
  rwhp_pkg::result_t out_res;
  logic              space;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rwhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .file_byte_i (s_axis_tdata[7:0]),
    .is_last_i   (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The queue decouples the two sides: bytes keep flowing while a result waits.
  rwhp_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {{(rwhp_pkg::OutDataW - rwhp_pkg::ResultW){1'b0}}, out_res};

endmodule

// ===== rtl/rwhp_parser.sv =====
`timescale 1ns / 1ps

module rwhp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         file_byte_i,
  input  logic               is_last_i,
  output logic               res_valid_o,
  output rwhp_pkg::result_t  res_o
);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_WAVE,
    PH_HEADER,
    PH_FMT,
    PH_SKIP,
    PH_IGNORE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [63:0] shift_q, shift_d;
  logic [32:0] remain_q, remain_d;
  logic [4:0]  index_q, index_d;
  logic        seen_q, seen_d;
  logic [15:0] chans_q, chans_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;

  logic [31:0] le32;
  logic [15:0] le16;
  logic [32:0] remain_dec;
  logic [32:0] padded_size;
  logic        emit;
  rwhp_pkg::status_e status;
  logic [31:0] offset;
  logic [31:0] dsize;

  // Little-endian views of the newest bytes, the incoming byte being the most significant.
  assign le32 = {file_byte_i, shift_q[7:0], shift_q[15:8], shift_q[23:16]};
  assign le16 = {file_byte_i, shift_q[7:0]};
  assign padded_size = {1'b0, le32} + {32'd0, le32[0]};
  assign remain_dec  = (remain_q != 33'd0) ? remain_q - 33'd1 : remain_q;

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    remain_d = remain_q;
    index_d  = index_q;
    seen_d   = seen_q;
    chans_d  = chans_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    emit     = 1'b0;
    status   = rwhp_pkg::ST_TRUNCATED;
    offset   = 32'd0;
    dsize    = 32'd0;
    res_valid_o = 1'b0;

    if (accept_i && (phase_q != PH_IGNORE)) begin
      shift_d = {shift_q[55:0], file_byte_i};
      pos_d   = pos_q + 32'd1;
      case (phase_q)
        PH_RIFF: begin
          if (pos_q == rwhp_pkg::RIFF_LAST_POS) begin
            if (shift_d[31:0] != rwhp_pkg::TAG_RIFF) begin
              emit   = 1'b1;
              status = rwhp_pkg::ST_NO_RIFF;
            end else begin
              phase_d = PH_WAVE;
            end
          end
        end
        PH_WAVE: begin
          if (pos_q == rwhp_pkg::WAVE_LAST_POS) begin
            if (shift_d[31:0] != rwhp_pkg::TAG_WAVE) begin
              emit   = 1'b1;
              status = rwhp_pkg::ST_NO_WAVE;
            end else begin
              phase_d = PH_HEADER;
              index_d = 5'd0;
            end
          end
        end
        PH_HEADER: begin
          index_d = index_q + 5'd1;
          if (index_q >= 5'd7) begin
            index_d = 5'd0;
            if (shift_d[63:32] == rwhp_pkg::TAG_FMT) begin
              if (le32 < rwhp_pkg::FMT_MIN_SIZE) begin
                emit   = 1'b1;
                status = rwhp_pkg::ST_FMT_SHORT;
              end else begin
                remain_d = padded_size;
                phase_d  = PH_FMT;
              end
            end else if (shift_d[63:32] == rwhp_pkg::TAG_DATA) begin
              emit   = 1'b1;
              status = seen_q ? rwhp_pkg::ST_OK : rwhp_pkg::ST_DATA_FIRST;
              offset = pos_d;
              dsize  = le32;
            end else begin
              remain_d = padded_size;
              if (padded_size != 33'd0) begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          remain_d = remain_dec;
          case (index_q)
            5'd1: begin
              if (le16 != rwhp_pkg::PCM_FORMAT) begin
                emit   = 1'b1;
                status = rwhp_pkg::ST_NOT_PCM;
              end
            end
            5'd3:    chans_d = le16;
            5'd7:    rate_d  = le32;
            5'd15: begin
              bits_d = le16;
              seen_d = 1'b1;
            end
            default: ;
          endcase
          index_d = index_q + 5'd1;
          if (!emit && (index_q >= 5'd15)) begin
            index_d = 5'd0;
            phase_d = (remain_dec == 33'd0) ? PH_HEADER : PH_SKIP;
          end
        end
        PH_SKIP: begin
          remain_d = remain_dec;
          if (remain_dec == 33'd0) begin
            phase_d = PH_HEADER;
            index_d = 5'd0;
          end
        end
        default: ;
      endcase

      if (emit || is_last_i) begin
        res_valid_o = 1'b1;
        phase_d     = PH_IGNORE;
      end
    end

    // The result carries the fields as updated by this byte.
    res_o.status        = status;
    res_o.channel_count = chans_d;
    res_o.rate_hz       = rate_d;
    res_o.sample_bits   = bits_d;
    res_o.body_start    = offset;
    res_o.body_len      = dsize;

    // A marked final byte always rearms from the reset state.
    if (accept_i && is_last_i) begin
      phase_d  = PH_RIFF;
      pos_d    = 32'd0;
      shift_d  = 64'd0;
      remain_d = 33'd0;
      index_d  = 5'd0;
      seen_d   = 1'b0;
      chans_d  = 16'd0;
      rate_d   = 32'd0;
      bits_d   = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      pos_q    <= 32'd0;
      shift_q  <= 64'd0;
      remain_q <= 33'd0;
      index_q  <= 5'd0;
      seen_q   <= 1'b0;
      chans_q  <= 16'd0;
      rate_q   <= 32'd0;
      bits_q   <= 16'd0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      shift_q  <= shift_d;
      remain_q <= remain_d;
      index_q  <= index_d;
      seen_q   <= seen_d;
      chans_q  <= chans_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
    end
  end

endmodule

// ===== rtl/rwhp_result_queue.sv =====
`timescale 1ns / 1ps

module rwhp_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rwhp_pkg::result_t  push_data_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output rwhp_pkg::result_t  data_o
);

  rwhp_pkg::result_t slot_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/rwhp_checker.sv =====
`timescale 1ns / 1ps
`include "riff_wav_header_parser_macros.svh"

module rwhp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rwhp_pkg::OutDataW-1:0] m_axis_tdata
);

  logic ok_like;

  assign ok_like = (m_axis_tdata[2:0] == rwhp_pkg::ST_OK) ||
                   (m_axis_tdata[2:0] == rwhp_pkg::ST_DATA_FIRST);

  // A held result keeps its payload until it is taken.
  `RWHP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Back pressure on the input only comes from results waiting at the output.
  `RWHP_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result pending")

  // A new result needs an input byte accepted on the edge before.
  `RWHP_ASSERT(a_result_cause, m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready), "result without an accepted byte")

  // Offset and size are only reported with a data chunk header.
  `RWHP_ASSERT(a_data_fields, m_axis_tvalid && !ok_like |-> m_axis_tdata[130:67] == 64'd0, "data fields set on an error status")

endmodule

bind riff_wav_header_parser rwhp_checker u_rwhp_checker (.*);

// ===== dv/wav_header_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of the WAV header parser, predicts the result of every file
// and compares each result request against the oldest prediction.
module wav_header_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [rwhp_pkg::InDataW-1:0]     in_byte_i,
  input  logic                             in_last_i,
  input  logic                             res_valid_i,
  input  logic                             res_ready_i,
  input  logic [rwhp_pkg::OutDataW-1:0]    res_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  localparam int unsigned MaxReports = 100;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_WAVE,
    PH_HEADER,
    PH_FMT,
    PH_SKIP,
    PH_IGNORE
  } parse_phase_e;

  // Parser state as the block is expected to hold it.
  logic [31:0]  byte_pos;
  logic [63:0]  recent_bytes;
  parse_phase_e phase;
  logic [32:0]  body_left;
  logic [4:0]   body_idx;
  logic         fmt_seen;
  logic [15:0]  cap_channels;
  logic [31:0]  cap_rate;
  logic [15:0]  cap_bits;
  logic [15:0]  cap_fmt_code;

  rwhp_pkg::result_t predicted_results[$];

  task automatic clear_parser();
    byte_pos      = '0;
    recent_bytes  = '0;
    phase         = PH_RIFF;
    body_left     = '0;
    body_idx      = '0;
    fmt_seen      = 1'b0;
    cap_channels  = '0;
    cap_rate      = '0;
    cap_bits      = '0;
    cap_fmt_code  = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (fail_count_o < MaxReports)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    fail_count_o++;
  endtask

  // Advances the parser by one file byte and queues the result it decides, if any.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] pos;
    logic [31:0] tag;
    logic [31:0] word_le;
    logic [15:0] half_le;
    logic [31:0] offset;
    logic [31:0] dsize;
    logic        decided;
    rwhp_pkg::status_e st;
    rwhp_pkg::result_t r;
    decided = 1'b0;
    st      = rwhp_pkg::ST_OK;
    offset  = '0;
    dsize   = '0;
    if (phase == PH_IGNORE) begin
      if (last) clear_parser();
      return;
    end
    recent_bytes = {recent_bytes[55:0], b};
    word_le  = {recent_bytes[7:0], recent_bytes[15:8], recent_bytes[23:16], recent_bytes[31:24]};
    half_le  = {recent_bytes[7:0], recent_bytes[15:8]};
    pos      = byte_pos;
    byte_pos = byte_pos + 32'd1;

    case (phase)
      PH_RIFF: begin
        if (pos == rwhp_pkg::RIFF_LAST_POS) begin
          if (recent_bytes[31:0] != rwhp_pkg::TAG_RIFF) begin
            decided = 1'b1;
            st      = rwhp_pkg::ST_NO_RIFF;
          end else begin
            phase = PH_WAVE;
          end
        end
      end
      PH_WAVE: begin
        if (pos == rwhp_pkg::WAVE_LAST_POS) begin
          if (recent_bytes[31:0] != rwhp_pkg::TAG_WAVE) begin
            decided = 1'b1;
            st      = rwhp_pkg::ST_NO_WAVE;
          end else begin
            phase    = PH_HEADER;
            body_idx = '0;
          end
        end
      end
      PH_HEADER: begin
        body_idx++;
        if (body_idx >= 5'd8) begin
          body_idx = '0;
          tag      = recent_bytes[63:32];
          if (tag == rwhp_pkg::TAG_FMT) begin
            if (word_le < rwhp_pkg::FMT_MIN_SIZE) begin
              decided = 1'b1;
              st      = rwhp_pkg::ST_FMT_SHORT;
            end else begin
              body_left = {1'b0, word_le} + 33'(word_le[0]);
              phase     = PH_FMT;
            end
          end else if (tag == rwhp_pkg::TAG_DATA) begin
            decided = 1'b1;
            st      = fmt_seen ? rwhp_pkg::ST_OK : rwhp_pkg::ST_DATA_FIRST;
            offset  = pos + 32'd1;
            dsize   = word_le;
          end else begin
            body_left = {1'b0, word_le} + 33'(word_le[0]);
            if (body_left != '0) phase = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (body_left != '0) body_left--;
        case (body_idx)
          5'd1: begin
            cap_fmt_code = half_le;
            if (cap_fmt_code != rwhp_pkg::PCM_FORMAT) begin
              decided = 1'b1;
              st      = rwhp_pkg::ST_NOT_PCM;
            end
          end
          5'd3:  cap_channels = half_le;
          5'd7:  cap_rate = word_le;
          5'd15: begin
            cap_bits = half_le;
            fmt_seen = 1'b1;
          end
          default: ;
        endcase
        body_idx++;
        if (!decided && body_idx >= 5'd16) begin
          body_idx = '0;
          phase    = (body_left == '0) ? PH_HEADER : PH_SKIP;
        end
      end
      default: begin
        if (body_left != '0) body_left--;
        if (body_left == '0) begin
          phase    = PH_HEADER;
          body_idx = '0;
        end
      end
    endcase

    if (!decided && !last) return;
    if (!decided) st = rwhp_pkg::ST_TRUNCATED;
    r.status        = st;
    r.channel_count = cap_channels;
    r.rate_hz       = cap_rate;
    r.sample_bits   = cap_bits;
    r.body_start    = offset;
    r.body_len      = dsize;
    predicted_results.push_back(r);
    if (last) clear_parser();
    else phase = PH_IGNORE;
  endtask

  // Results are checked before the byte of the same edge is predicted, since a
  // result always belongs to an earlier byte.
  always @(posedge clk_i) begin : watch
    rwhp_pkg::result_t got;
    rwhp_pkg::result_t want;
    if (!rst_ni) begin
      clear_parser();
      predicted_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[rwhp_pkg::ResultW-1:0];
        if (res_data_i[rwhp_pkg::OutDataW-1:rwhp_pkg::ResultW] != '0)
          report_mismatch("padding",
                          32'(res_data_i[rwhp_pkg::OutDataW-1:rwhp_pkg::ResultW]), 32'd0);
        if (predicted_results.size() == 0) begin
          report_mismatch("result with none expected, status", 32'(got.status), 32'd0);
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.channel_count !== want.channel_count)
            report_mismatch("channel_count", 32'(got.channel_count), 32'(want.channel_count));
          if (got.rate_hz !== want.rate_hz)
            report_mismatch("rate_hz", got.rate_hz, want.rate_hz);
          if (got.sample_bits !== want.sample_bits)
            report_mismatch("sample_bits", 32'(got.sample_bits), 32'(want.sample_bits));
          if (got.body_start !== want.body_start)
            report_mismatch("body_start", got.body_start, want.body_start);
          if (got.body_len !== want.body_len)
            report_mismatch("body_len", got.body_len, want.body_len);
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(in_byte_i, in_last_i);
      pending_o <= predicted_results.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the WAV header parser bench. This module only builds files and drives the
// two streams; the checker beside the block predicts and compares every result.
module tb_top;

  // Percent of cycles in which a side rests, per idling phase.
  localparam int unsigned SenderIdlePct    = 56;
  localparam int unsigned ReceiverStallPct = 56;
  localparam int unsigned BothIdlePct      = 16;
  // Length of the one long receiver hold-off, long enough to fill the result queue.
  localparam int unsigned LongHoldCycles   = 400;
  // Stimulus stops once both of these are reached.
  localparam int unsigned TargetBytes      = 1350;
  localparam int unsigned TargetFiles      = 28;
  localparam int unsigned FilesPerPhase    = 7;
  // Settle time after the last result has been taken; this is a wide margin.
  localparam int unsigned SettleCycles     = 20;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Shapes of generated files. Most are well formed up to the point that decides
  // their result; the rest break one check, stop early or are plain noise.
  typedef enum logic [3:0] {
    FK_GOOD,
    FK_CUT,
    FK_BAD_RIFF,
    FK_BAD_WAVE,
    FK_FMT_SHORT,
    FK_NOT_PCM,
    FK_DATA_FIRST,
    FK_HUGE_BODY,
    FK_NOISE,
    FK_COUNT
  } file_kind_e;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rwhp_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                           s_axis_tlast  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rwhp_pkg::OutDataW-1:0]  m_axis_tdata;

  int unsigned fail_count;
  int unsigned results_pending;

  idle_mode_e  idle_mode     = IDLE_NONE;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned bytes_sent    = 0;

  logic [7:0] file_img[$];

  always #1 clk_i = ~clk_i;

  riff_wav_header_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wav_header_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  // Result side. A pending hold-off request from the stimulus process starts a long
  // stretch of tready low, counted down here; otherwise the idling phase decides.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: m_axis_tready <= ($urandom_range(0, 99) >= ReceiverStallPct);
        IDLE_BOTH:     m_axis_tready <= ($urandom_range(0, 99) >= BothIdlePct);
        default:       m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Values that are usually random but now and then sit at an extreme.
  function automatic logic [31:0] extreme_or_random();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A chunk tag that is neither fmt nor data; half the time it is one bit away from
  // one of them so near misses of the tag compare get exercised.
  function automatic logic [31:0] other_tag();
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0:       t = rwhp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
      1:       t = rwhp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
      default: t = $urandom;
    endcase
    if (t == rwhp_pkg::TAG_FMT || t == rwhp_pkg::TAG_DATA) t = t ^ 32'd1;
    return t;
  endfunction

  // Tags go out in reading order, first character first.
  task automatic put_tag(input logic [31:0] tag);
    file_img.push_back(tag[31:24]);
    file_img.push_back(tag[23:16]);
    file_img.push_back(tag[15:8]);
    file_img.push_back(tag[7:0]);
  endtask

  task automatic put_le16(input logic [15:0] v);
    file_img.push_back(v[7:0]);
    file_img.push_back(v[15:8]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endtask

  task automatic put_random_bytes(input int unsigned n);
    repeat (n) file_img.push_back(8'($urandom));
  endtask

  // Chunk header followed by n body bytes; n need not match the size field.
  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size,
                           input int unsigned n);
    put_tag(tag);
    put_le32(size);
    put_random_bytes(n);
  endtask

  // fmt chunk: the 16 standard body bytes when the size allows, then extra bytes.
  task automatic put_fmt(input logic [31:0] size, input logic [15:0] fmt_code,
                         input int unsigned extra);
    put_tag(rwhp_pkg::TAG_FMT);
    put_le32(size);
    if (size >= rwhp_pkg::FMT_MIN_SIZE) begin
      put_le16(fmt_code);
      put_le16(16'(extreme_or_random()));
      put_le32(extreme_or_random());
      put_le32($urandom);
      put_le16(16'($urandom));
      put_le16(16'(extreme_or_random()));
      put_random_bytes(extra);
    end
  endtask

  // A fmt chunk that passes all checks, with an optional tail and pad byte.
  task automatic put_good_fmt();
    logic [31:0] sz;
    sz = rwhp_pkg::FMT_MIN_SIZE + $urandom_range(0, 3);
    put_fmt(sz, rwhp_pkg::PCM_FORMAT, int'(sz - rwhp_pkg::FMT_MIN_SIZE) + int'(sz[0]));
  endtask

  task automatic trim_file(input int unsigned keep);
    while (file_img.size() > keep) void'(file_img.pop_back());
  endtask

  task automatic build_file(input file_kind_e kind);
    int unsigned k;
    logic [31:0] sz;
    logic [15:0] af;
    file_img.delete();
    if (kind == FK_NOISE) begin
      put_random_bytes($urandom_range(1, 12));
      return;
    end
    put_tag(rwhp_pkg::TAG_RIFF);
    put_le32($urandom);
    put_tag(rwhp_pkg::TAG_WAVE);
    // A broken tag: the rest of the file is ignored, so keep it short.
    if (kind == FK_BAD_RIFF || kind == FK_BAD_WAVE) begin
      k = (kind == FK_BAD_RIFF) ? $urandom_range(0, 3) : $urandom_range(8, 11);
      file_img[k] = file_img[k] ^ 8'($urandom_range(1, 255));
      trim_file($urandom_range((kind == FK_BAD_RIFF) ? 4 : 12, 12));
      return;
    end
    // Unknown chunks ahead of fmt, including empty ones and odd sizes with a pad byte.
    repeat ($urandom_range(0, 2)) begin
      sz = $urandom_range(0, 7);
      put_chunk(other_tag(), sz, int'(sz) + int'(sz[0]));
    end
    case (kind)
      FK_DATA_FIRST: begin
        put_chunk(rwhp_pkg::TAG_DATA, extreme_or_random(), $urandom_range(0, 2));
        return;
      end
      FK_FMT_SHORT: begin
        put_fmt($urandom_range(0, 15), rwhp_pkg::PCM_FORMAT, 0);
        put_random_bytes($urandom_range(0, 3));
        return;
      end
      FK_NOT_PCM: begin
        af = 16'(extreme_or_random());
        if (af == rwhp_pkg::PCM_FORMAT) af = 16'd0;
        put_fmt(rwhp_pkg::FMT_MIN_SIZE, af, 0);
        return;
      end
      FK_HUGE_BODY: begin
        // The body can never be walked through, so the file ends inside it.
        sz = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) put_chunk(other_tag(), sz, $urandom_range(0, 6));
        else put_fmt(sz, rwhp_pkg::PCM_FORMAT, $urandom_range(0, 6));
        return;
      end
      default: ;
    endcase
    put_good_fmt();
    // Sometimes a second fmt chunk, whose fields must win.
    if ($urandom_range(0, 3) == 0) put_good_fmt();
    if ($urandom_range(0, 1) == 0) begin
      sz = $urandom_range(0, 5);
      put_chunk(other_tag(), sz, int'(sz) + int'(sz[0]));
    end
    put_chunk(rwhp_pkg::TAG_DATA, extreme_or_random(), $urandom_range(0, 3));
    // A cut file ends anywhere: in a header, a skipped body or the fmt body.
    if (kind == FK_CUT) trim_file($urandom_range(1, file_img.size() - 1));
  endtask

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < SenderIdlePct;
      IDLE_BOTH:   return $urandom_range(0, 99) < BothIdlePct;
      default:     return 1'b0;
    endcase
  endfunction

  // Offers one byte from a falling edge and returns at the falling edge after the
  // rising edge that accepted the request. tvalid stays high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (sender_rests()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int unsigned i = 0; i < file_img.size(); i++)
      send_byte(file_img[i], i == file_img.size() - 1);
  endtask

  // Stops offering bytes until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_pending != 0);
  endtask

  initial begin
    int unsigned fno;
    int unsigned r;
    file_kind_e  kind;
    fno = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed files: a lone final byte at both extremes, a bad RIFF tag followed by
    // bytes that must be ignored, a file that ends right after a good RIFF tag, and a
    // bad WAVE tag decided on the marked byte itself, which rearms at once.
    file_img = '{8'hFF};
    send_file();
    file_img = '{8'h00};
    send_file();
    file_img.delete();
    put_tag(rwhp_pkg::TAG_RIFF ^ 32'h0000_0080);
    put_random_bytes(2);
    send_file();
    file_img.delete();
    put_tag(rwhp_pkg::TAG_RIFF);
    send_file();
    file_img.delete();
    put_tag(rwhp_pkg::TAG_RIFF);
    put_le32(32'h0000_0000);
    put_tag(rwhp_pkg::TAG_WAVE ^ 32'h0100_0000);
    send_file();

    // Random files. Each idling phase starts from an empty pipeline, and early on
    // the receiver holds off long enough for the block to stall its input.
    while (fno < TargetFiles || bytes_sent < TargetBytes) begin
      if (fno % FilesPerPhase == 0) begin
        drain_results();
        idle_mode <= idle_mode_e'((fno / FilesPerPhase) % 4);
        @(negedge clk_i);
      end
      if (fno == 2) hold_requests <= hold_requests + 1;
      if (fno < FK_COUNT) begin
        kind = file_kind_e'(fno);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40)      kind = FK_GOOD;
        else if (r < 55) kind = FK_CUT;
        else if (r < 61) kind = FK_BAD_RIFF;
        else if (r < 67) kind = FK_BAD_WAVE;
        else if (r < 74) kind = FK_FMT_SHORT;
        else if (r < 81) kind = FK_NOT_PCM;
        else if (r < 88) kind = FK_DATA_FIRST;
        else if (r < 94) kind = FK_HUGE_BODY;
        else             kind = FK_NOISE;
      end
      build_file(kind);
      send_file();
      fno++;
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long hold-off.
  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== riff_wav_header_parser.f =====
+incdir+rtl
rtl/rwhp_pkg.sv
rtl/rwhp_parser.sv
rtl/rwhp_result_queue.sv
rtl/riff_wav_header_parser.sv
rtl/rwhp_checker.sv
dv/wav_header_checker.sv
dv/tb_top.sv
